// ----- rtl/core/rsbk_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsbk_pkg
// shared types and default sizes for the record sorter
// ----------------------------------------------------------------------------
package rsbk_pkg;

    localparam int MAX_RECORDS_DEF  = 64;
    localparam int KEY_BITS_DEF     = 32;
    localparam int PAYLOAD_BITS_DEF = 32;

    // controller to datapath commands
    typedef struct packed {
        logic load;   // store the incoming request
        logic last;   // incoming request closes the batch
        logic scan;   // walk the store looking for the next record
        logic emit;   // present the selected record
    } cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic scan_done;  // last candidate compared this cycle
        logic batch_end;  // record being emitted is the final one
    } sts_t;

endpackage

// ----- rtl/core/rsbk_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsbk_ctrl
// sequencer: load, scan for next record, emit
// ----------------------------------------------------------------------------
module rsbk_ctrl
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic          last,
    input  rsbk_pkg::sts_t sts,
    output rsbk_pkg::cmd_t cmd,
    output logic          busy,
    output logic          done
);

    typedef enum logic [1:0] {ST_LOAD, ST_SCAN, ST_EMIT} state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_LOAD:
            begin
                if (start && last)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (sts.scan_done)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                state_next = sts.batch_end ? ST_LOAD : ST_SCAN;
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy     = (state_reg != ST_LOAD);
    assign done     = (state_reg == ST_EMIT);
    assign cmd.load = start && (state_reg == ST_LOAD);
    assign cmd.last = last;
    assign cmd.scan = (state_reg == ST_SCAN);
    assign cmd.emit = (state_reg == ST_EMIT);

endmodule

// ----- rtl/core/rsbk_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsbk_dp
// record store, scan compare and output registers
// ----------------------------------------------------------------------------
module rsbk_dp
#(
    parameter int MAX_RECORDS  = rsbk_pkg::MAX_RECORDS_DEF,
    parameter int KEY_BITS     = rsbk_pkg::KEY_BITS_DEF,
    parameter int PAYLOAD_BITS = rsbk_pkg::PAYLOAD_BITS_DEF
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  rsbk_pkg::cmd_t                 cmd,
    input  logic signed [KEY_BITS-1:0]     key,
    input  logic        [PAYLOAD_BITS-1:0] payload,
    output rsbk_pkg::sts_t                 sts,
    output logic signed [KEY_BITS-1:0]     sorted_key,
    output logic        [PAYLOAD_BITS-1:0] sorted_payload,
    output logic                           end_of_batch,
    output logic                           dropped
);

    localparam int AW = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;
    localparam int CW = $clog2(MAX_RECORDS + 1);
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_RECORDS);

    logic [KEY_BITS+PAYLOAD_BITS-1:0] mem [MAX_RECORDS];

    logic [CW-1:0] count_reg, scan_reg, emit_cnt_reg;
    logic          ovf_reg, rv_reg, best_v_reg, have_last_reg;
    logic [AW-1:0] ridx_reg, best_idx_reg, last_idx_reg;
    logic [KEY_BITS+PAYLOAD_BITS-1:0] rdata_reg;
    logic signed [KEY_BITS-1:0] best_key_reg, last_key_reg;
    logic [PAYLOAD_BITS-1:0]    best_pay_reg;

    logic signed [KEY_BITS-1:0] rkey;
    logic issue, after_last, beats_best, take;

    assign issue = cmd.scan && (scan_reg < count_reg);
    assign rkey  = rdata_reg[KEY_BITS+PAYLOAD_BITS-1:PAYLOAD_BITS];

    // lexicographic order on (key, arrival index) keeps ties stable
    assign after_last = !have_last_reg || (rkey > last_key_reg) ||
                        ((rkey == last_key_reg) && (ridx_reg > last_idx_reg));
    assign beats_best = !best_v_reg || (rkey < best_key_reg);
    assign take       = rv_reg && after_last && beats_best;

    always_ff @(posedge clk)
    begin
        if (cmd.load && (count_reg < MAX_CNT))
        begin
            mem[count_reg[AW-1:0]] <= {key, payload};
        end
        rdata_reg <= mem[scan_reg[AW-1:0]];
        ridx_reg  <= scan_reg[AW-1:0];
        if (take)
        begin
            best_key_reg <= rkey;
            best_pay_reg <= rdata_reg[PAYLOAD_BITS-1:0];
            best_idx_reg <= ridx_reg;
        end
        if (cmd.emit)
        begin
            last_key_reg <= best_key_reg;
            last_idx_reg <= best_idx_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            scan_reg      <= '0;
            rv_reg        <= 1'b0;
            best_v_reg    <= 1'b0;
            have_last_reg <= 1'b0;
            emit_cnt_reg  <= '0;
        end
        else
        begin
            rv_reg <= issue;
            if (issue)
            begin
                scan_reg <= scan_reg + 1'b1;
            end
            if (take)
            begin
                best_v_reg <= 1'b1;
            end
            if (cmd.load)
            begin
                if (count_reg < MAX_CNT)
                begin
                    count_reg <= count_reg + 1'b1;
                end
                else
                begin
                    ovf_reg <= 1'b1;
                end
                scan_reg   <= '0;
                best_v_reg <= 1'b0;
            end
            if (cmd.emit)
            begin
                scan_reg      <= '0;
                best_v_reg    <= 1'b0;
                have_last_reg <= 1'b1;
                emit_cnt_reg  <= emit_cnt_reg + 1'b1;
                if (sts.batch_end)
                begin
                    count_reg     <= '0;
                    ovf_reg       <= 1'b0;
                    have_last_reg <= 1'b0;
                    emit_cnt_reg  <= '0;
                end
            end
        end
    end

    assign sts.scan_done = rv_reg && (ridx_reg == AW'(count_reg - 1'b1));
    assign sts.batch_end = (emit_cnt_reg == (count_reg - 1'b1));

    assign sorted_key     = best_key_reg;
    assign sorted_payload = best_pay_reg;
    assign end_of_batch   = sts.batch_end;
    assign dropped        = ovf_reg;

    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= MAX_CNT) else $error("record count over capacity");
    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit && sts.batch_end |=> count_reg == '0 && !ovf_reg)
        else $error("batch state not cleared after final record");
    a_read_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        rv_reg |-> CW'(ridx_reg) < count_reg)
        else $error("scan read beyond stored records");
    a_emit_has_best: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> best_v_reg) else $error("emit without selected record");

endmodule

// ----- rtl/core/record_sort_by_key.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// record_sort_by_key
// batch sorter: collects key/payload records, returns them by ascending key
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; one request per
// cycle while loading. Requests past MAX_RECORDS are discarded and every
// result of that batch shows dropped. The request with last set closes the
// batch; busy then stays high until the final result. Results come out with
// done high for exactly one cycle each and cannot be held off by the
// receiver. Equal keys leave in arrival order. Each result costs one full
// pass over the n stored records through the single read port of the store,
// so a batch of n records drains in n such passes. There is no clearing
// pass after reset.
// ----------------------------------------------------------------------------
module record_sort_by_key
#(
    parameter int MAX_RECORDS  = rsbk_pkg::MAX_RECORDS_DEF,
    parameter int KEY_BITS     = rsbk_pkg::KEY_BITS_DEF,
    parameter int PAYLOAD_BITS = rsbk_pkg::PAYLOAD_BITS_DEF
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic signed [KEY_BITS-1:0]     key,
    input  logic        [PAYLOAD_BITS-1:0] payload,
    input  logic                           last,
    output logic                           done,
    output logic signed [KEY_BITS-1:0]     sorted_key,
    output logic        [PAYLOAD_BITS-1:0] sorted_payload,
    output logic                           end_of_batch,
    output logic                           dropped
);

    rsbk_pkg::cmd_t cmd;   // sequencer commands
    rsbk_pkg::sts_t sts;   // scan and batch status

    // sequencer: load until last, then alternate scan and emit
    rsbk_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .last  (last),
        .sts   (sts),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    // store plus the next-greater search over (key, arrival index)
    rsbk_dp
    #(
        .MAX_RECORDS  (MAX_RECORDS),
        .KEY_BITS     (KEY_BITS),
        .PAYLOAD_BITS (PAYLOAD_BITS)
    )
    u_dp
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .key            (key),
        .payload        (payload),
        .sts            (sts),
        .sorted_key     (sorted_key),
        .sorted_payload (sorted_payload),
        .end_of_batch   (end_of_batch),
        .dropped        (dropped)
    );

endmodule

// ----- bench/record_sort_by_key_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// record_sort_by_key_test
// self-checking bench for the batch record sorter: loads batches of
// key/payload requests, predicts the stable ascending output order and
// compares every result field by field, with random start gaps
// ----------------------------------------------------------------------------
module record_sort_by_key_test;

    localparam int NREC  = rsbk_pkg::MAX_RECORDS_DEF;
    localparam int KW    = rsbk_pkg::KEY_BITS_DEF;
    localparam int PW    = rsbk_pkg::PAYLOAD_BITS_DEF;
    localparam int STALL_LIMIT = 40000;

    typedef struct {
        logic signed [KW-1:0] key;
        logic        [PW-1:0] payload;
        logic                 eob;
        logic                 drop;
    } sorted_rec_t;

    // one row of the directed table; chk marks a typed-in expectation
    typedef struct {
        logic signed [KW-1:0] key;
        logic        [PW-1:0] payload;
        logic                 last;
        logic                 chk;
        logic signed [KW-1:0] exp_key;
        logic        [PW-1:0] exp_payload;
    } dir_row_t;

    logic                 clk;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    logic signed [KW-1:0] key;
    logic        [PW-1:0] payload;
    logic                 last;
    logic                 done;
    logic signed [KW-1:0] sorted_key;
    logic        [PW-1:0] sorted_payload;
    logic                 end_of_batch;
    logic                 dropped;

    // predictor state: records held for the open batch
    logic signed [KW-1:0] held_key [NREC];
    logic        [PW-1:0] held_pay [NREC];
    int                   held_cnt;
    logic                 held_lost;

    sorted_rec_t          pending_sorted [$];
    sorted_rec_t          typed_exp [$];
    int                   mismatches;
    int                   idle_cycles;
    logic                 quiet;

    record_sort_by_key u_dut
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .key            (key),
        .payload        (payload),
        .last           (last),
        .done           (done),
        .sorted_key     (sorted_key),
        .sorted_payload (sorted_payload),
        .end_of_batch   (end_of_batch),
        .dropped        (dropped)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    task automatic report_mismatch(input string what);
        begin
            $display("mismatch at %0t: %s", $time, what);
            mismatches++;
        end
    endtask

    // store one request; on last, sort stably and queue every result
    task automatic predict_sorted(input logic signed [KW-1:0] k, input logic [PW-1:0] p,
                                  input logic lst);
        int i;
        int j;
        logic signed [KW-1:0] ck;
        logic        [PW-1:0] cp;
        sorted_rec_t r;
        begin
            if (held_cnt < NREC)
            begin
                held_key[held_cnt] = k;
                held_pay[held_cnt] = p;
                held_cnt++;
            end
            else
                held_lost = 1'b1;
            if (lst)
            begin
                for (i = 1; i < held_cnt; i++)
                begin
                    ck = held_key[i];
                    cp = held_pay[i];
                    j = i;
                    while (j > 0 && held_key[j-1] > ck)
                    begin
                        held_key[j] = held_key[j-1];
                        held_pay[j] = held_pay[j-1];
                        j--;
                    end
                    held_key[j] = ck;
                    held_pay[j] = cp;
                end
                for (i = 0; i < held_cnt; i++)
                begin
                    r.key = held_key[i];
                    r.payload = held_pay[i];
                    r.eob = (i + 1 == held_cnt);
                    r.drop = held_lost;
                    pending_sorted.push_back(r);
                end
                held_cnt = 0;
                held_lost = 1'b0;
            end
        end
    endtask

    // drive one request and wait until it is taken; start stays high
    // afterwards until a gap or the end of stimulus drops it
    task automatic send_request(input logic signed [KW-1:0] k, input logic [PW-1:0] p,
                                input logic lst);
        int gap;
        begin
            if (!quiet && $urandom_range(0, 3) == 0)
            begin
                gap = $urandom_range(1, 14);
                start <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            start <= 1'b1;
            key <= k;
            payload <= p;
            last <= lst;
            @(posedge clk);
            while (busy)
                @(posedge clk);
            predict_sorted(k, p, lst);
        end
    endtask

    // result checker, sampled at the edge that ends the strobe cycle
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (pending_sorted.size() == 0)
                report_mismatch("result with nothing expected");
            else
            begin
                sorted_rec_t e;
                e = pending_sorted.pop_front();
                if (sorted_key !== e.key)
                    report_mismatch($sformatf("sorted_key %h exp %h", sorted_key, e.key));
                if (sorted_payload !== e.payload)
                    report_mismatch($sformatf("sorted_payload %h exp %h",
                                              sorted_payload, e.payload));
                if (end_of_batch !== e.eob)
                    report_mismatch($sformatf("end_of_batch %b exp %b", end_of_batch, e.eob));
                if (dropped !== e.drop)
                    report_mismatch($sformatf("dropped %b exp %b", dropped, e.drop));
                if (typed_exp.size() > 0)
                begin
                    sorted_rec_t t;
                    t = typed_exp.pop_front();
                    if (sorted_key !== t.key || sorted_payload !== t.payload)
                        report_mismatch("directed row value differs");
                end
            end
        end
    end

    // watchdog on cycles without any accepted request or result
    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial
    begin
        dir_row_t rows [$];
        dir_row_t d;
        sorted_rec_t t;
        int n;
        int i;
        int b;
        int sent;
        logic signed [KW-1:0] k;

        rst_n = 1'b0;
        start = 1'b0;
        key = '0;
        payload = '0;
        last = 1'b0;
        held_cnt = 0;
        held_lost = 1'b0;
        mismatches = 0;
        idle_cycles = 0;
        quiet = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // single record batch with extreme values, typed-in results
        rows.push_back('{32'sh7fffffff, 32'hffffffff, 1'b1, 1'b1, 32'sh7fffffff, 32'hffffffff});
        // extremes of key, descending arrival, predicted ascending output
        rows.push_back('{32'sh7fffffff, 32'h00000001, 1'b0, 1'b0, 0, 0});
        rows.push_back('{32'sh00000000, 32'h00000002, 1'b0, 1'b0, 0, 0});
        rows.push_back('{-32'sh1, 32'h00000003, 1'b0, 1'b0, 0, 0});
        rows.push_back('{32'sh80000000, 32'h00000000, 1'b1, 1'b0, 0, 0});
        // equal keys must leave in arrival order
        rows.push_back('{32'sh00000005, 32'haaaa0001, 1'b0, 1'b0, 0, 0});
        rows.push_back('{32'sh00000005, 32'haaaa0002, 1'b0, 1'b0, 0, 0});
        rows.push_back('{-32'sh5, 32'h55555555, 1'b0, 1'b0, 0, 0});
        rows.push_back('{32'sh00000005, 32'haaaa0003, 1'b1, 1'b0, 0, 0});
        foreach (rows[r])
        begin
            d = rows[r];
            if (d.chk)
            begin
                t.key = d.exp_key;
                t.payload = d.exp_payload;
                typed_exp.push_back(t);
            end
            send_request(d.key, d.payload, d.last);
        end

        // overflow: a full store, then extra records, last one discarded too
        for (i = 0; i < NREC + 3; i++)
            send_request($urandom, $urandom, i == NREC + 2);

        // random batches, small, with narrow key ranges in every third batch for ties
        sent = 0;
        b = 0;
        while (sent < 44)
        begin
            if (sent > 30)
                quiet = 1'b1;
            n = $urandom_range(1, 6);
            for (i = 0; i < n; i++)
            begin
                k = $urandom;
                if (b % 3 == 0)
                    k = $signed(k) >>> 28;
                send_request(k, $urandom, i == n - 1);
            end
            sent += n;
            b++;
        end
        start <= 1'b0;

        while (pending_sorted.size() > 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (mismatches == 0 && typed_exp.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ----- record_sort_by_key.f -----
rtl/core/rsbk_pkg.sv
rtl/core/rsbk_ctrl.sv
rtl/core/rsbk_dp.sv
rtl/core/record_sort_by_key.sv
bench/record_sort_by_key_test.sv
